[rtl/sobel_edge_magnitude_defines.svh]
// Assertion macros shared by the edge magnitude RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

// Condition must never hold while out of reset
`define SEM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define SEM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/sem_pkg.sv]
// Shared constants and types of the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int ROW_W     = FH_W + 1;
    localparam int SUM_W     = 10;
    localparam int WSUM_W    = SUM_W + 2;
    localparam int SX_W      = WSUM_W + 1;
    localparam int SQ_W      = 24;
    localparam int Q_W       = SQ_W + 1;
    localparam int ACC_W     = Q_W + 1;
    localparam int EDGE_W    = 8;
    localparam int SQ_STAGES = EDGE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_DRAIN = 1'b1;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH = 16;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // One window step handed from the front to the back
    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic [SUM_W-1:0] sum;
        logic [7:0]       alpha;
        logic             emit;
        logic             edge_col;
        logic             left_rep;
        logic             top_rep;
        logic             bot_rep;
        logic             last;
    } t_op;

    // Squared gradient on its way to the root unit
    typedef struct packed {
        logic           vld;
        logic [Q_W-1:0] q;
        logic [7:0]     alpha;
        logic           last;
    } t_mag;

    // Finished result item
    typedef struct packed {
        logic [EDGE_W-1:0] edge_value;
        logic [7:0]        alpha;
        logic              last;
    } t_res;

endpackage

[rtl/sem_front.sv]
// Front end: accepts items, tracks frame position and drain count, issues window steps.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_action,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_alpha,
    input  logic                          i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output sem_pkg::t_op                  o_q_op
);
    import sem_pkg::*;

    logic [FW_W-1:0]   r_frame_width;
    logic [FH_W-1:0]   r_frame_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [PEND_W-1:0] r_pend, n_pend;
    logic              r_second, n_second;

    logic [EW_W-1:0]   w_eff;
    logic [FH_W-1:0]   h_eff;
    logic [ROW_W-1:0]  h_row, h_row_p1;
    logic [COL_W:0]    col_inc;
    logic              acc, cfg_hit, do_arr, is_drain;
    logic              at_edge, at_norm, emit;
    logic [SUM_W-1:0]  pix_sum;

    // Effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = EW_W'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = EW_W'(MAX_WIDTH);
        end else begin
            w_eff = EW_W'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    end

    assign h_row    = {1'b0, h_eff};
    assign h_row_p1 = h_row + ROW_W'(1);
    assign col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
    assign pix_sum  = SUM_W'(i_red) + SUM_W'(i_green) + SUM_W'(i_blue);
    assign o_full   = r_second || i_q_full;
    assign acc      = i_push && !o_full;
    assign cfg_hit  = i_cfg_we &&
                      (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT);

    // Classify the item and form the window step at the current position
    always_comb begin
        do_arr   = 1'b0;
        is_drain = 1'b0;
        if (r_second) begin
            do_arr   = !i_q_full;
            is_drain = 1'b1;
        end else if (acc) begin
            if (i_action == ACTION_PIXEL) begin
                do_arr = (r_pend == '0);
            end else begin
                do_arr   = (r_pend != '0);
                is_drain = 1'b1;
            end
        end

        at_edge = (r_col == '0) && (r_row >= ROW_W'(2));
        at_norm = (r_col != '0) && (r_row >= ROW_W'(1));
        emit    = at_edge || at_norm;

        o_q_op.addr     = r_col;
        o_q_op.sum      = is_drain ? '0 : pix_sum;
        o_q_op.alpha    = is_drain ? '0 : i_alpha;
        o_q_op.emit     = emit;
        o_q_op.edge_col = at_edge;
        o_q_op.left_rep = at_edge ? (w_eff == EW_W'(1)) : (r_col == COL_W'(1));
        o_q_op.top_rep  = at_edge ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        o_q_op.bot_rep  = at_edge ? (r_row == h_row_p1) : (r_row == h_row);
        o_q_op.last     = is_drain && (r_pend == PEND_W'(1));
        o_q_push        = do_arr;

        n_col    = r_col;
        n_row    = r_row;
        n_pend   = r_pend;
        n_second = r_second;
        if (do_arr) begin
            // advance position
            if (32'(col_inc) >= 32'(w_eff)) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
            if (is_drain) begin
                n_second = !emit;
                if (emit) begin
                    n_pend = r_pend - PEND_W'(1);
                    if (r_pend == PEND_W'(1)) begin
                        n_col = '0;
                        n_row = '0;
                    end
                end
            end else if (n_row == h_row && n_col == '0) begin
                n_pend = (h_eff >= FH_W'(2)) ? PEND_W'(w_eff) + PEND_W'(1) : PEND_W'(w_eff);
            end
        end
        // a write to the width or height register restarts the frame
        if (cfg_hit) begin
            n_col    = '0;
            n_row    = '0;
            n_pend   = '0;
            n_second = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Position and drain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= '0;
            r_second <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_pend   <= n_pend;
            r_second <= n_second;
        end
    end

    `SEM_ASSERT_NEVER(a_second_needs_pend, r_second && (r_pend == '0), "second step with nothing owed")

endmodule

[rtl/sem_op_queue.sv]
// Short queue of window steps between front and back.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_op_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  sem_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output sem_pkg::t_op o_op
);
    import sem_pkg::*;

    t_op                r_mem [MQ_DEPTH];
    logic [MQ_PTR_W-1:0] r_wr, r_rd;
    logic [MQ_CNT_W-1:0] r_cnt;
    logic               wr, rd;

    assign o_full  = (32'(r_cnt) == MQ_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd];

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_op;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wr <= (32'(r_wr) == MQ_DEPTH - 1) ? '0 : r_wr + MQ_PTR_W'(1);
            end
            if (rd) begin
                r_rd <= (32'(r_rd) == MQ_DEPTH - 1) ? '0 : r_rd + MQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + MQ_CNT_W'(wr) - MQ_CNT_W'(rd);
        end
    end

    `SEM_ASSERT_NEVER(a_mq_no_overflow, i_push && o_full, "step pushed into full queue")

endmodule

[rtl/sem_back.sv]
// Back end: line stores, 3x3 window, Sobel sums and squares.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sem_pkg::t_op  i_q_op,
    output logic          o_q_pop,
    input  logic          i_res_pop,
    output sem_pkg::t_mag o_mag
);
    import sem_pkg::*;

    // Weighted column or row sum a + 2b + c
    function automatic logic [WSUM_W-1:0] wsum(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b,
                                               input logic [SUM_W-1:0] c);
        return WSUM_W'(a) + (WSUM_W'(b) << 1) + WSUM_W'(c);
    endfunction

    logic [2*SUM_W-1:0] line_mem  [MAX_WIDTH];
    logic [7:0]         alpha_mem [MAX_WIDTH];

    logic [OQ_CNT_W-1:0] r_resv;
    logic                launch;
    logic                r_b_vld;
    t_op                 r_b_op;
    logic [2*SUM_W-1:0]  r_rd_line, r_byp_line, b_line;
    logic [7:0]          r_rd_alpha, r_byp_alpha, b_alpha, r_alpha_dly;
    logic                r_byp;
    logic [SUM_W-1:0]    r_w1 [3];
    logic [SUM_W-1:0]    r_w2 [3];
    logic [SUM_W-1:0]    b_new [3];
    logic [SUM_W-1:0]    col_l [3];
    logic [SUM_W-1:0]    col_c [3];
    logic [SUM_W-1:0]    col_r [3];
    logic [SUM_W-1:0]    p_l [3];
    logic [SUM_W-1:0]    p_c [3];
    logic [SUM_W-1:0]    p_r [3];
    logic [WSUM_W-1:0]   ws_l, ws_r, ws_t, ws_b;

    logic                   r_c_vld, r_d_vld, r_e_vld;
    logic signed [SX_W-1:0] r_c_sx, r_c_sy;
    logic signed [2*SX_W-1:0] sxx_full, syy_full;
    logic [SQ_W-1:0]        r_d_sxx, r_d_syy;
    logic [Q_W-1:0]         r_e_q;
    logic [7:0]             r_c_alpha, r_d_alpha, r_e_alpha;
    logic                   r_c_last, r_d_last, r_e_last;

    // Issue a step only when the result queue has room reserved
    assign launch  = !i_q_empty && (32'(r_resv) < OQ_DEPTH);
    assign o_q_pop = launch;

    // Line stores: read at issue, write back in the window stage
    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_rd_line  <= line_mem[i_q_op.addr];
            r_rd_alpha <= alpha_mem[i_q_op.addr];
        end
        if (r_b_vld) begin
            line_mem[r_b_op.addr]  <= {b_line[SUM_W-1:0], r_b_op.sum};
            alpha_mem[r_b_op.addr] <= r_b_op.alpha;
        end
    end

    // Forward data written in the same cycle as a read of that column
    always_ff @(posedge i_clk) begin
        r_byp_line  <= {b_line[SUM_W-1:0], r_b_op.sum};
        r_byp_alpha <= r_b_op.alpha;
        r_b_op      <= i_q_op;
    end

    assign b_line  = r_byp ? r_byp_line : r_rd_line;
    assign b_alpha = r_byp ? r_byp_alpha : r_rd_alpha;

    // Select window columns and replicate border rows
    always_comb begin
        b_new[0] = b_line[2*SUM_W-1:SUM_W];
        b_new[1] = b_line[SUM_W-1:0];
        b_new[2] = r_b_op.sum;
        for (int i = 0; i < 3; i++) begin
            col_l[i] = r_b_op.left_rep ? r_w2[i] : r_w1[i];
            col_c[i] = r_w2[i];
            col_r[i] = r_b_op.edge_col ? r_w2[i] : b_new[i];
        end
        p_l[1] = col_l[1];
        p_c[1] = col_c[1];
        p_r[1] = col_r[1];
        p_l[0] = r_b_op.top_rep ? col_l[1] : col_l[0];
        p_c[0] = r_b_op.top_rep ? col_c[1] : col_c[0];
        p_r[0] = r_b_op.top_rep ? col_r[1] : col_r[0];
        p_l[2] = r_b_op.bot_rep ? col_l[1] : col_l[2];
        p_c[2] = r_b_op.bot_rep ? col_c[1] : col_c[2];
        p_r[2] = r_b_op.bot_rep ? col_r[1] : col_r[2];
        ws_l = wsum(p_l[0], p_l[1], p_l[2]);
        ws_r = wsum(p_r[0], p_r[1], p_r[2]);
        ws_t = wsum(p_l[0], p_c[0], p_r[0]);
        ws_b = wsum(p_l[2], p_c[2], p_r[2]);
    end

    assign sxx_full = r_c_sx * r_c_sx;
    assign syy_full = r_c_sy * r_c_sy;

    // Shift the window and carry the gradient down the pipe
    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_w1        <= r_w2;
            r_w2        <= b_new;
            r_alpha_dly <= b_alpha;
        end
        r_c_sx    <= $signed({1'b0, ws_r}) - $signed({1'b0, ws_l});
        r_c_sy    <= $signed({1'b0, ws_b}) - $signed({1'b0, ws_t});
        r_c_alpha <= r_alpha_dly;
        r_c_last  <= r_b_op.last;
        r_d_sxx   <= SQ_W'(sxx_full);
        r_d_syy   <= SQ_W'(syy_full);
        r_d_alpha <= r_c_alpha;
        r_d_last  <= r_c_last;
        r_e_q     <= Q_W'(r_d_sxx) + Q_W'(r_d_syy);
        r_e_alpha <= r_d_alpha;
        r_e_last  <= r_d_last;
    end

    // Stage valids, bypass flag and result reservation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_byp   <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_resv  <= '0;
        end else begin
            r_b_vld <= launch;
            r_byp   <= launch && r_b_vld && (i_q_op.addr == r_b_op.addr);
            r_c_vld <= r_b_vld && r_b_op.emit;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_resv  <= r_resv + OQ_CNT_W'(launch && i_q_op.emit) - OQ_CNT_W'(i_res_pop);
        end
    end

    assign o_mag.vld   = r_e_vld;
    assign o_mag.q     = r_e_q;
    assign o_mag.alpha = r_e_alpha;
    assign o_mag.last  = r_e_last;

    `SEM_ASSERT_NEVER(a_resv_bound, 32'(r_resv) > OQ_DEPTH, "result reservation overrun")
    `SEM_ASSERT_NEXT(a_byp_follows, r_byp, $past(r_b_vld, 2), "bypass without a writing step")

endmodule

[rtl/sem_sqrt.sv]
// Pipelined root unit: largest m with 9*m*m <= q, one result bit per stage.
// Depends on sem_pkg.
module sem_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sem_pkg::t_mag i_mag,
    output logic          o_res_vld,
    output sem_pkg::t_res o_res
);
    import sem_pkg::*;

    typedef struct packed {
        logic              vld;
        logic [Q_W-1:0]    q;
        logic [EDGE_W-1:0] m;
        logic [ACC_W-1:0]  sq;
        logic [7:0]        alpha;
        logic              last;
    } t_sq_stage;

    t_sq_stage        r_stg [SQ_STAGES];
    t_sq_stage        src   [SQ_STAGES];
    t_sq_stage        nxt   [SQ_STAGES];
    logic [ACC_W-1:0] bitv  [SQ_STAGES];
    logic [ACC_W-1:0] tinc  [SQ_STAGES];
    logic [ACC_W-1:0] cand  [SQ_STAGES];

    // Try one bit per stage: 9*(m+b)^2 = 9*m^2 + 9*(2m+b)*b
    always_comb begin
        src[0].vld   = i_mag.vld;
        src[0].q     = i_mag.q;
        src[0].m     = '0;
        src[0].sq    = '0;
        src[0].alpha = i_mag.alpha;
        src[0].last  = i_mag.last;
        for (int s = 1; s < SQ_STAGES; s++) begin
            src[s] = r_stg[s-1];
        end
        for (int s = 0; s < SQ_STAGES; s++) begin
            bitv[s] = ACC_W'(1) << (SQ_STAGES - 1 - s);
            tinc[s] = ((ACC_W'(src[s].m) << 1) + bitv[s]) << (SQ_STAGES - 1 - s);
            cand[s] = src[s].sq + tinc[s] + (tinc[s] << 3);
            nxt[s]  = src[s];
            if (cand[s] <= ACC_W'(src[s].q)) begin
                nxt[s].m  = src[s].m | EDGE_W'(bitv[s]);
                nxt[s].sq = cand[s];
            end
        end
    end

    // Advance stages
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQ_STAGES; s++) begin
            if (!i_rst_n) begin
                r_stg[s] <= '0;
            end else begin
                r_stg[s] <= nxt[s];
            end
        end
    end

    assign o_res_vld        = r_stg[SQ_STAGES-1].vld;
    assign o_res.edge_value = r_stg[SQ_STAGES-1].m;
    assign o_res.alpha      = r_stg[SQ_STAGES-1].alpha;
    assign o_res.last       = r_stg[SQ_STAGES-1].last;

endmodule

[rtl/sem_out_queue.sv]
// Result queue presented on the output side.
// Depends on sem_pkg and sobel_edge_magnitude_defines.svh.
`include "sobel_edge_magnitude_defines.svh"
module sem_out_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sem_pkg::t_res i_res,
    input  logic          i_pop,
    output logic          o_empty,
    output sem_pkg::t_res o_res
);
    import sem_pkg::*;

    t_res                r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr, r_rd;
    logic [OQ_CNT_W-1:0] r_cnt;
    logic                full, rd;

    assign full    = (32'(r_cnt) == OQ_DEPTH);
    assign o_empty = (r_cnt == '0);
    assign rd      = i_pop && !o_empty;
    assign o_res   = r_mem[r_rd];

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (32'(r_wr) == OQ_DEPTH - 1) ? '0 : r_wr + OQ_PTR_W'(1);
            end
            if (rd) begin
                r_rd <= (32'(r_rd) == OQ_DEPTH - 1) ? '0 : r_rd + OQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + OQ_CNT_W'(i_push) - OQ_CNT_W'(rd);
        end
    end

    `SEM_ASSERT_NEVER(a_oq_no_overflow, i_push && full, "result pushed into full queue")

endmodule

[rtl/sobel_edge_magnitude.sv]
// Throughput: one item per cycle while the step queue and the result reservation have room,
// set by the single line-store port and the window stage; the first drain item of a
// single-row frame takes two window steps, and full stays high until the second one issues.
// Reset: synchronous, active low; clears counters, queues and config (640 x 480).
// Line stores are not cleared; border replication keeps stale entries out of every result.
module sobel_edge_magnitude (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_action,
    input  logic [7:0]                     i_blue,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_red,
    input  logic [7:0]                     i_alpha,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_edge_value,
    output logic [7:0]                     o_alpha_out,
    output logic                           o_frame_end
);
    import sem_pkg::*;

    logic q_push, q_full, q_pop, q_empty, res_vld, res_pop;
    t_op  f_op, b_op;
    t_mag mag;
    t_res res, head;

    assign res_pop = pop && !empty;

    sem_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_action   (i_action),
        .i_blue     (i_blue),
        .i_green    (i_green),
        .i_red      (i_red),
        .i_alpha    (i_alpha),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_op     (f_op)
    );

    sem_op_queue u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_op    (b_op)
    );

    sem_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_op    (b_op),
        .o_q_pop   (q_pop),
        .i_res_pop (res_pop),
        .o_mag     (mag)
    );

    sem_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mag     (mag),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    sem_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_res   (res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (head)
    );

    assign o_edge_value = head.edge_value;
    assign o_alpha_out  = head.alpha;
    assign o_frame_end  = head.last;

endmodule

[sim/tb.sv]
// Self-checking testbench for sobel_edge_magnitude: random and directed pixel frames
// against an internal edge-magnitude predictor. Depends on rtl/sem_pkg.sv and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    typedef struct {
        logic       action;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } pixel_item_t;

    typedef struct {
        logic [7:0] edge_value;
        logic [7:0] alpha;
        logic       frame_end;
    } edge_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_action = ACTION_PIXEL;
    logic [7:0]            i_blue = '0;
    logic [7:0]            i_green = '0;
    logic [7:0]            i_red = '0;
    logic [7:0]            i_alpha = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            o_edge_value;
    logic [7:0]            o_alpha_out;
    logic                  o_frame_end;

    sobel_edge_magnitude uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_alpha      (i_alpha),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .empty        (empty),
        .pop          (pop),
        .o_edge_value (o_edge_value),
        .o_alpha_out  (o_alpha_out),
        .o_frame_end  (o_frame_end)
    );

    // Stimulus and expectation stores
    pixel_item_t  pixel_q[$];
    edge_result_t edge_expect_q[$];
    int           err_cnt = 0;
    int           item_cnt = 0;
    int           result_cnt = 0;
    int           frame_cnt = 0;
    int           cfg_cnt = 0;
    bit           calm = 1'b0;
    logic         took = 1'b0;
    int           push_gap = 0;
    int           pop_gap = 0;

    // Predictor state
    logic [9:0]   line_sum[2*MAX_WIDTH];
    logic [7:0]   line_alpha[MAX_WIDTH];
    logic [9:0]   win[9];
    logic [7:0]   alpha_dly;
    logic [10:0]  cfg_w;
    logic [15:0]  cfg_h;
    int unsigned  col_pos;
    int unsigned  row_pos;
    int unsigned  owed;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_w();
        if (cfg_w == 0) return 1;
        if (cfg_w > MAX_WIDTH) return MAX_WIDTH;
        return cfg_w;
    endfunction

    function automatic int unsigned eff_h();
        return (cfg_h == 0) ? 1 : cfg_h;
    endfunction

    // Sobel gradient over window columns, rows replicated at the top and bottom border
    function automatic logic [7:0] grad_mag(int lc, int cc, int rc, int unsigned y,
                                            int unsigned h);
        int          p[3][3];
        int          src;
        int          sx;
        int          sy;
        int unsigned q9;
        int unsigned m;
        int unsigned cand;
        for (int i = 0; i < 3; i++) begin
            src = i;
            if (i == 0 && y == 0) src = 1;
            if (i == 2 && y == h - 1) src = 1;
            p[i][0] = win[src*3+lc];
            p[i][1] = win[src*3+cc];
            p[i][2] = win[src*3+rc];
        end
        sx = (p[0][2] + 2*p[1][2] + p[2][2]) - (p[0][0] + 2*p[1][0] + p[2][0]);
        sy = (p[2][0] + 2*p[2][1] + p[2][2]) - (p[0][0] + 2*p[0][1] + p[0][2]);
        q9 = (sx*sx + sy*sy) / 9;
        m = 0;
        for (int unsigned b = 128; b != 0; b >>= 1) begin
            cand = m | b;
            if (cand * cand <= q9) m = cand;
        end
        return m[7:0];
    endfunction

    // Shift one sum into the window; return whether an output is formed
    function automatic bit slide_window(logic [9:0] s, logic [7:0] a,
                                        output logic [7:0] v, output logic [7:0] ca);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic [9:0]  old0;
        logic [9:0]  old1;
        bit          n;
        w = eff_w();
        h = eff_h();
        r = row_pos;
        c = col_pos;
        n = 0;
        v = '0;
        ca = alpha_dly;
        if (c >= w) c = 0;
        if (c == 0 && r >= 2) begin
            v = grad_mag((w == 1) ? 2 : 1, 2, 2, r - 2, h);
            n = 1;
        end
        alpha_dly = line_alpha[c];
        line_alpha[c] = a;
        old0 = line_sum[c];
        old1 = line_sum[MAX_WIDTH+c];
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = old0;
        win[5] = old1;
        win[8] = s;
        line_sum[c] = old1;
        line_sum[MAX_WIDTH+c] = s;
        if (c >= 1 && r >= 1) begin
            v = grad_mag((c == 1) ? 1 : 0, 1, 2, r - 1, h);
            n = 1;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        col_pos = c;
        row_pos = r;
        return n;
    endfunction

    // Work out the result, if any, of one accepted item
    function automatic void sobel_predict_item(pixel_item_t it);
        edge_result_t res;
        logic [9:0]   s;
        bit           n;
        s = 10'(it.blue) + 10'(it.green) + 10'(it.red);
        if (it.action == ACTION_PIXEL) begin
            if (owed > 0) return;
            n = slide_window(s, it.alpha, res.edge_value, res.alpha);
            if (row_pos == eff_h() && col_pos == 0)
                owed = (eff_h() >= 2) ? eff_w() + 1 : eff_w();
            res.frame_end = 1'b0;
            if (n) edge_expect_q.push_back(res);
            return;
        end
        if (owed == 0) return;
        n = slide_window('0, '0, res.edge_value, res.alpha);
        if (!n) n = slide_window('0, '0, res.edge_value, res.alpha);
        if (!n) return;
        owed--;
        res.frame_end = (owed == 0);
        if (owed == 0) begin
            col_pos = 0;
            row_pos = 0;
        end
        edge_expect_q.push_back(res);
    endfunction

    // Mirror accepted items and register writes into the predictor
    always @(posedge i_clk) begin
        pixel_item_t it;
        if (i_rst_n) begin
            took <= push && !full;
            if (push && !full) begin
                it.action = i_action;
                it.blue   = i_blue;
                it.green  = i_green;
                it.red    = i_red;
                it.alpha  = i_alpha;
                sobel_predict_item(it);
                item_cnt++;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) cfg_w = i_cfg_data[10:0];
                else if (i_cfg_idx == REG_FRAME_HEIGHT) cfg_h = i_cfg_data;
                col_pos = 0;
                row_pos = 0;
                owed = 0;
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        edge_result_t exp_res;
        if (i_rst_n && pop && !empty) begin
            result_cnt++;
            if (edge_expect_q.size() == 0) begin
                $display("%0t: unexpected item: edge %0d alpha %0d end %0b", $time,
                         o_edge_value, o_alpha_out, o_frame_end);
                err_cnt++;
            end else begin
                exp_res = edge_expect_q.pop_front();
                if (o_edge_value !== exp_res.edge_value) begin
                    $display("%0t: edge_value expected %0d actual %0d", $time,
                             exp_res.edge_value, o_edge_value);
                    err_cnt++;
                end
                if (o_alpha_out !== exp_res.alpha) begin
                    $display("%0t: alpha_out expected %0d actual %0d", $time,
                             exp_res.alpha, o_alpha_out);
                    err_cnt++;
                end
                if (o_frame_end !== exp_res.frame_end) begin
                    $display("%0t: frame_end expected %0b actual %0b", $time,
                             exp_res.frame_end, o_frame_end);
                    err_cnt++;
                end
            end
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold the item until taken, then advance after an optional gap
    always @(negedge i_clk) begin
        pixel_item_t it;
        if (i_rst_n && !(push && !took)) begin
            if (push_gap > 0) begin
                push <= 1'b0;
                push_gap <= push_gap - 1;
            end else if (pixel_q.size() > 0) begin
                it = pixel_q.pop_front();
                i_action <= it.action;
                i_blue   <= it.blue;
                i_green  <= it.green;
                i_red    <= it.red;
                i_alpha  <= it.alpha;
                push     <= 1'b1;
                push_gap <= draw_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else begin
                pop <= 1'b1;
                pop_gap <= draw_gap();
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic void add_item(logic act, logic [7:0] b, logic [7:0] g,
                                     logic [7:0] r, logic [7:0] a);
        pixel_item_t it;
        it.action = act;
        it.blue   = b;
        it.green  = g;
        it.red    = r;
        it.alpha  = a;
        pixel_q.push_back(it);
    endfunction

    function automatic void add_rand_pixel();
        add_item(ACTION_PIXEL, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endfunction

    // Queue one full frame plus its drains, with some ignored noise mixed in
    function automatic void add_frame(int unsigned w, int unsigned h, bit noisy);
        int unsigned drains;
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                add_item(ACTION_DRAIN, rand_byte(), rand_byte(), rand_byte(), rand_byte());
            add_rand_pixel();
        end
        drains = (h >= 2) ? w + 1 : w;
        for (int unsigned i = 0; i < drains; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) add_rand_pixel();
            add_item(ACTION_DRAIN, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        end
        if (noisy && $urandom_range(0, 3) == 0)
            add_item(ACTION_DRAIN, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        frame_cnt++;
    endfunction

    task automatic wait_idle();
        while (pixel_q.size() > 0 || push || edge_expect_q.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_cnt++;
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        foreach (line_sum[i]) line_sum[i] = '0;
        foreach (line_alpha[i]) line_alpha[i] = '0;
        foreach (win[i]) win[i] = '0;
        alpha_dly = '0;
        cfg_w = FRAME_WIDTH_RST;
        cfg_h = FRAME_HEIGHT_RST;
        col_pos = 0;
        row_pos = 0;
        owed = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: run into the second row, then abort by a register write
        for (int i = 0; i < 645; i++) add_rand_pixel();

        // Directed 4x3 frame: extremes, alternating bits, drain with nothing owed
        set_frame(4, 3);
        add_item(ACTION_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
        add_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_item(ACTION_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
        add_item(ACTION_PIXEL, 8'hAA, 8'h55, 8'hAA, 8'h55);
        add_item(ACTION_PIXEL, 8'h55, 8'hAA, 8'h55, 8'hAA);
        add_item(ACTION_PIXEL, 8'h00, 8'h00, 8'h00, 8'h01);
        add_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        add_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h7F);
        add_item(ACTION_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFE);
        add_item(ACTION_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h11);
        add_item(ACTION_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'h22);
        add_item(ACTION_PIXEL, 8'h01, 8'h80, 8'h7F, 8'h33);
        add_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h44);
        add_item(ACTION_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h55);
        add_item(ACTION_DRAIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < 4; i++) add_item(ACTION_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
        add_item(ACTION_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00);
        frame_cnt++;

        // Zero width and height act as a single pixel
        set_frame(0, 0);
        add_frame(1, 1, 1'b1);
        add_frame(1, 1, 1'b0);
        // One column
        set_frame(1, 5);
        add_frame(1, 5, 1'b1);
        // Single row
        set_frame(5, 1);
        add_frame(5, 1, 1'b1);
        // Largest height, aborted part way by the next write
        set_frame(3, 16'hFFFF);
        for (int i = 0; i < 10; i++) add_rand_pixel();

        // Random geometries and frames
        while (item_cnt < 800) begin
            calm = ($urandom_range(0, 3) == 0);
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_frame(16'(w), 16'(h));
            repeat ($urandom_range(1, 3)) add_frame(w, h, 1'b1);
        end
        calm = 1'b0;
        wait_idle();

        $display("Ran %0d items in %0d frames over %0d register writes,", item_cnt,
                 frame_cnt, cfg_cnt);
        $display("checked %0d results with %0d mismatches.", result_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Global timeout
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/sem_pkg.sv
rtl/sem_front.sv
rtl/sem_op_queue.sv
rtl/sem_back.sv
rtl/sem_sqrt.sv
rtl/sem_out_queue.sv
rtl/sobel_edge_magnitude.sv
sim/tb.sv
